// ----- design/okrl_pkg.sv -----
package okrl_pkg;

  // Field widths of the item on each channel.
  localparam int CmdW    = 4;
  localparam int KeyW    = 32;
  localparam int ValW    = 10;
  localparam int PosInW  = 5;
  localparam int StatW   = 2;
  localparam int TotW    = 5;

  // Default number of records the list holds.
  localparam int CapacityDef = 16;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_PUSH_FRONT = 4'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_BACK  = 4'd1;
  localparam logic [CmdW-1:0] CMD_POP_FRONT  = 4'd2;
  localparam logic [CmdW-1:0] CMD_POP_BACK   = 4'd3;
  localparam logic [CmdW-1:0] CMD_INSERT     = 4'd4;
  localparam logic [CmdW-1:0] CMD_LOOKUP     = 4'd5;
  localparam logic [CmdW-1:0] CMD_REMOVE     = 4'd6;
  localparam logic [CmdW-1:0] CMD_UPDATE     = 4'd7;
  localparam logic [CmdW-1:0] CMD_SCAN       = 4'd8;

  // Result status codes.
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_MISS  = 2'd2;
  localparam logic [StatW-1:0] ST_FULL  = 2'd3;

  // Cell update modes broadcast along the chain.
  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_SHIFT  = 2'd2;
  localparam logic [1:0] MODE_ROTATE = 2'd3;

  // One stored record.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } okrl_rec_t;

  // Control sent to every cell in a cycle.
  typedef struct packed {
    logic [1:0] mode;
    okrl_rec_t  ins;
  } okrl_bcast_t;

endpackage

// ----- design/okrl_ifs.sv -----
// Command channel.
interface okrl_in_if;
  import okrl_pkg::*;
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [KeyW-1:0]   key;
  logic [ValW-1:0]   value;
  logic [PosInW-1:0] position;
  logic [ValW-1:0]   threshold;

  modport source (output valid, command, key, value, position, threshold, input ready);
  modport sink (input valid, command, key, value, position, threshold, output ready);
endinterface

// Result channel.
interface okrl_out_if;
  import okrl_pkg::*;
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [KeyW-1:0]  out_key;
  logic [ValW-1:0]  out_value;
  logic [TotW-1:0]  entry_total;
  logic             last;

  modport source (output valid, status, out_key, out_value, entry_total, last, input ready);
  modport sink (input valid, status, out_key, out_value, entry_total, last, output ready);
endinterface

// ----- design/ordered_keyed_record_list.sv -----
// Ordered keyed record list: up to CAPACITY records (32-bit key, 10-bit value)
// kept front to back in a chain of cells.
// in_ch carries one command item per valid/ready handshake; out_ch returns the
// result items, each with status, key, value, record count and a last flag.
// Push front, push back, insert, pop front, unused codes and any command on an
// empty list need no walk: the result item is on out_ch the cycle after
// the command is taken.
// Pop back, lookup, remove, update and scan on a non-empty list walk it once by
// rotating the chain through its head cell, one record a cycle while no result
// item waits on a stalled receiver; after the walk a finish state puts the final
// result item in the result register and so on out_ch.
// A scan streams one item per matching record, front to back; each match is
// sent once the next one turns up, and the last one leaves at the end of the walk.
// A new command is taken only once the previous one has delivered its final
// result, at the earliest at the same edge at which that item is accepted.
// With a ready receiver, commands with no walk are taken back to back, one a cycle.
// While a result item waits on a stalled receiver, no command is taken and the
// walk pauses with it; nothing is lost.
// Reset (synchronous, active low) empties the list and the result register.
module ordered_keyed_record_list #(
  parameter int CAPACITY = okrl_pkg::CapacityDef
) (
  input logic clk,
  input logic rst_n,
  okrl_in_if.sink    in_ch,
  okrl_out_if.source out_ch
);
  import okrl_pkg::*;

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > PosInW) ? CntW : PosInW;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [CntW-1:0] steps_r, steps_nxt;
  logic [CmdW-1:0] cmd_r, cmd_nxt;
  logic [KeyW-1:0] key_r, key_nxt;
  logic [ValW-1:0] val_r, val_nxt;
  logic [ValW-1:0] thr_r, thr_nxt;
  logic            found_r, found_nxt;
  okrl_rec_t       held_r, held_nxt;
  logic            held_valid_r, held_valid_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [StatW-1:0] out_status_r;
  okrl_rec_t        out_rec_r;
  logic [TotW-1:0]  out_total_r;
  logic             out_last_r;

  okrl_bcast_t     bc;
  logic [CntW-1:0] cell_pos;
  okrl_rec_t       cell_rec [CAPACITY];
  okrl_rec_t       head;
  okrl_rec_t       rec_mod;
  logic            slot_free;
  logic            in_acc;
  logic            full;
  logic            empty;
  logic            hit;
  logic [CntW-1:0] pos_clamp;

  logic             emit;
  logic [StatW-1:0] em_status;
  okrl_rec_t        em_rec;
  logic             em_last;

  // Chain of cells.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    okrl_rec_t left_rec;
    okrl_rec_t right_rec;
    if (i == 0) begin : g_first
      assign left_rec = bc.ins;
    end else begin : g_mid_l
      assign left_rec = cell_rec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_rec = cell_rec[i];
    end else begin : g_mid_r
      assign right_rec = cell_rec[i+1];
    end
    okrl_cell #(
      .CNT_W (CntW),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .bc        (bc),
      .pos       (cell_pos),
      .left_rec  (left_rec),
      .right_rec (right_rec),
      .cell_rec  (cell_rec[i])
    );
  end

  assign head      = cell_rec[0];
  assign slot_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign full      = (count_r == CntW'(CAPACITY));
  assign empty     = (count_r == '0);
  assign pos_clamp = (CmpW'(in_ch.position) >= CmpW'(count_r)) ? count_r
                                                               : CntW'(in_ch.position);

  // Does the record at the head of the chain take part in this walk step.
  always_comb begin
    case (cmd_r)
      CMD_POP_BACK: hit = (steps_r == CntW'(1));
      CMD_SCAN:     hit = (head.value >= thr_r);
      default:      hit = !found_r && (head.key == key_r);
    endcase
    rec_mod = head;
    if (cmd_r == CMD_UPDATE && hit) begin
      rec_mod.value = val_r;
    end
  end

  // Command sequencing and chain control.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    steps_nxt      = steps_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    thr_nxt        = thr_r;
    found_nxt      = found_r;
    held_nxt       = held_r;
    held_valid_nxt = held_valid_r;
    bc.mode        = MODE_HOLD;
    bc.ins         = rec_mod;
    cell_pos       = '0;
    emit           = 1'b0;
    em_status      = ST_OK;
    em_rec         = '0;
    em_last        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt        = in_ch.command;
          key_nxt        = in_ch.key;
          val_nxt        = in_ch.value;
          thr_nxt        = in_ch.threshold;
          found_nxt      = 1'b0;
          held_valid_nxt = 1'b0;
          steps_nxt      = count_r;
          case (in_ch.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
              emit = 1'b1;
              if (full) begin
                em_status = ST_FULL;
              end else begin
                bc.mode       = MODE_INSERT;
                bc.ins.key    = in_ch.key;
                bc.ins.value  = in_ch.value;
                count_nxt     = count_r + 1'b1;
                if (in_ch.command == CMD_PUSH_FRONT) begin
                  cell_pos = '0;
                end else if (in_ch.command == CMD_PUSH_BACK) begin
                  cell_pos = count_r;
                end else begin
                  cell_pos = pos_clamp;
                end
              end
            end
            CMD_POP_FRONT: begin
              emit = 1'b1;
              if (empty) begin
                em_status = ST_EMPTY;
              end else begin
                bc.mode   = MODE_SHIFT;
                em_rec    = head;
                count_nxt = count_r - 1'b1;
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                emit      = 1'b1;
                em_status = ST_EMPTY;
              end else begin
                state_nxt = S_WALK;
              end
            end
            CMD_LOOKUP, CMD_REMOVE, CMD_UPDATE, CMD_SCAN: begin
              if (empty) begin
                emit      = 1'b1;
                em_status = ST_MISS;
              end else begin
                state_nxt = S_WALK;
              end
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      S_WALK: begin
        if (slot_free) begin
          // Drop the head record on a removal, otherwise send it to the tail.
          if (hit && (cmd_r == CMD_REMOVE || cmd_r == CMD_POP_BACK)) begin
            bc.mode   = MODE_SHIFT;
            count_nxt = count_r - 1'b1;
          end else begin
            bc.mode  = MODE_ROTATE;
            cell_pos = count_r - 1'b1;
          end
          // A scan releases the previous match once a later one turns up.
          if (hit) begin
            found_nxt      = 1'b1;
            held_nxt       = rec_mod;
            held_valid_nxt = 1'b1;
            if (cmd_r == CMD_SCAN && held_valid_r) begin
              emit    = 1'b1;
              em_rec  = held_r;
              em_last = 1'b0;
            end
          end
          steps_nxt = steps_r - 1'b1;
          if (steps_r == CntW'(1)) begin
            state_nxt = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (held_valid_r) begin
            em_rec = held_r;
          end else begin
            em_status = ST_MISS;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      held_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      found_r      <= found_nxt;
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    cmd_r   <= cmd_nxt;
    key_r   <= key_nxt;
    val_r   <= val_nxt;
    thr_r   <= thr_nxt;
    held_r  <= held_nxt;
    if (emit) begin
      out_status_r <= em_status;
      out_rec_r    <= em_rec;
      out_total_r  <= TotW'(count_nxt);
      out_last_r   <= em_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.out_key     = out_rec_r.key;
  assign out_ch.out_value   = out_rec_r.value;
  assign out_ch.entry_total = out_total_r;
  assign out_ch.last        = out_last_r;

  // The record count never goes past the capacity.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(CAPACITY))
    else $error("record count exceeds capacity");

  // A walk never grows the list.
  a_walk_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> (count_r <= $past(count_r)))
    else $error("record count grew during a walk");

  // Only a scan leaves a result item that is not the last.
  a_not_last_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (cmd_r == CMD_SCAN))
    else $error("non-final result from a command other than scan");

  // A pop back walk always ends holding the removed record.
  a_pop_back_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && cmd_r == CMD_POP_BACK) |-> held_valid_r)
    else $error("pop back finished without a record");

endmodule

// ----- design/okrl_cell.sv -----
module okrl_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                  clk,
  input  okrl_pkg::okrl_bcast_t bc,
  input  logic [CNT_W-1:0]      pos,
  input  okrl_pkg::okrl_rec_t   left_rec,
  input  okrl_pkg::okrl_rec_t   right_rec,
  output okrl_pkg::okrl_rec_t   cell_rec
);
  import okrl_pkg::*;

  localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

  okrl_rec_t rec_r;
  okrl_rec_t rec_nxt;
  logic      at_pos;
  logic      past_pos;

  assign at_pos   = (MyIdx == pos);
  assign past_pos = (MyIdx > pos);

  // Pick this cell's next record from the broadcast or a neighbor.
  always_comb begin
    rec_nxt = rec_r;
    case (bc.mode)
      MODE_INSERT: begin
        if (at_pos) begin
          rec_nxt = bc.ins;
        end else if (past_pos) begin
          rec_nxt = left_rec;
        end
      end
      MODE_SHIFT: begin
        rec_nxt = right_rec;
      end
      MODE_ROTATE: begin
        rec_nxt = at_pos ? bc.ins : right_rec;
      end
      default: begin
        rec_nxt = rec_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign cell_rec = rec_r;

endmodule

// ----- test/ordered_keyed_record_list_tb.sv -----
module ordered_keyed_record_list_tb;
  import okrl_pkg::*;

  // Codes past scan are unused and must leave the list alone.
  localparam logic [CmdW-1:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [CmdW-1:0] CMD_UNUSED_HI = 4'd15;

  // Cycles with no item moving on either channel before the run is abandoned.
  localparam int WatchdogLimit = 2000;
  // Settling time after the last result: a full walk of the list plus margin.
  localparam int SettleCycles = CapacityDef + 8;

  // One result item as the list should report it.
  typedef struct packed {
    logic [StatW-1:0] status;
    logic [KeyW-1:0]  key;
    logic [ValW-1:0]  value;
    logic [TotW-1:0]  total;
    logic             last;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  okrl_in_if  in_ch ();
  okrl_out_if out_ch ();

  ordered_keyed_record_list dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the list and the results it is owed.
  logic [KeyW-1:0] list_key [CapacityDef];
  logic [ValW-1:0] list_val [CapacityDef];
  int              list_len = 0;
  list_result_t    owed_results [$];

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_cycles  = 0;
  int mismatches   = 0;
  int quiet_cycles = 0;
  int cmds_taken   = 0;
  int results_seen = 0;

  function automatic void owe_result(input logic [StatW-1:0] status,
                                     input logic [KeyW-1:0] key,
                                     input logic [ValW-1:0] value,
                                     input logic last);
    list_result_t r;
    r.status = status;
    r.key    = key;
    r.value  = value;
    r.total  = TotW'(list_len);
    r.last   = last;
    owed_results.push_back(r);
  endfunction

  // Close the gap left by the record at slot.
  function automatic void drop_record(input int slot);
    for (int i = slot; i + 1 < list_len; i++) begin
      list_key[i] = list_key[i + 1];
      list_val[i] = list_val[i + 1];
    end
    list_len--;
  endfunction

  // Apply one command to the shadow list and queue the results it causes.
  function automatic void apply_list_command(input logic [CmdW-1:0] cmd,
                                             input logic [KeyW-1:0] key,
                                             input logic [ValW-1:0] val,
                                             input logic [PosInW-1:0] pos,
                                             input logic [ValW-1:0] thr);
    int slot;
    int match_cnt;
    int emitted;
    logic [KeyW-1:0] got_key;
    logic [ValW-1:0] got_val;
    slot = -1;
    match_cnt = 0;
    emitted = 0;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
        if (list_len >= CapacityDef) begin
          owe_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) slot = 0;
          else if (cmd == CMD_PUSH_BACK || int'(pos) > list_len) slot = list_len;
          else slot = int'(pos);
          for (int i = list_len; i > slot; i--) begin
            list_key[i] = list_key[i - 1];
            list_val[i] = list_val[i - 1];
          end
          list_key[slot] = key;
          list_val[slot] = val;
          list_len++;
          owe_result(ST_OK, '0, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (list_len == 0) begin
          owe_result(ST_EMPTY, '0, '0, 1'b1);
        end else begin
          slot = (cmd == CMD_POP_FRONT) ? 0 : list_len - 1;
          got_key = list_key[slot];
          got_val = list_val[slot];
          drop_record(slot);
          owe_result(ST_OK, got_key, got_val, 1'b1);
        end
      end
      CMD_LOOKUP, CMD_REMOVE, CMD_UPDATE: begin
        for (int i = 0; i < list_len; i++) begin
          if (slot < 0 && list_key[i] == key) slot = i;
        end
        if (slot < 0) begin
          owe_result(ST_MISS, '0, '0, 1'b1);
        end else begin
          if (cmd == CMD_UPDATE) list_val[slot] = val;
          got_key = list_key[slot];
          got_val = list_val[slot];
          if (cmd == CMD_REMOVE) drop_record(slot);
          owe_result(ST_OK, got_key, got_val, 1'b1);
        end
      end
      CMD_SCAN: begin
        for (int i = 0; i < list_len; i++) begin
          if (list_val[i] >= thr) match_cnt++;
        end
        if (match_cnt == 0) begin
          owe_result(ST_MISS, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_len; i++) begin
            if (list_val[i] >= thr) begin
              emitted++;
              owe_result(ST_OK, list_key[i], list_val[i], emitted == match_cnt);
            end
          end
        end
      end
      default: begin
        owe_result(ST_OK, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Check each result against the oldest owed one, then predict from the
  // command taken at this edge; a watchdog tracks cycles with no handshake.
  always @(posedge clk) begin
    list_result_t want;
    list_result_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got.status = out_ch.status;
        got.key    = out_ch.out_key;
        got.value  = out_ch.out_value;
        got.total  = out_ch.entry_total;
        got.last   = out_ch.last;
        if (owed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status=%0d key=%h value=%0d total=%0d last=%0b",
                     got.status, got.key, got.value, got.total, got.last);
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status || got.key !== want.key ||
              got.value !== want.value || got.total !== want.total ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected status=%0d key=%h value=%0d total=%0d last=%0b",
                       want.status, want.key, want.value, want.total, want.last);
              $display("          got      status=%0d key=%h value=%0d total=%0d last=%0b",
                       got.status, got.key, got.value, got.total, got.last);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cmds_taken++;
        apply_list_command(in_ch.command, in_ch.key, in_ch.value, in_ch.position,
                           in_ch.threshold);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("timeout: no item moved for %0d cycles", quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Offer one command and hold it until the list takes it. Valid stays high
  // afterwards so back-to-back commands need no second assignment.
  task automatic send_command(input logic [CmdW-1:0] cmd, input logic [KeyW-1:0] key,
                              input logic [ValW-1:0] val, input logic [PosInW-1:0] pos,
                              input logic [ValW-1:0] thr);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.key       <= key;
    in_ch.value     <= val;
    in_ch.position  <= pos;
    in_ch.threshold <= thr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Stop offering and wait for every owed result.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Keys mostly come from a small pool so lookups hit and duplicates occur.
  function automatic logic [KeyW-1:0] pick_key();
    case ($urandom_range(9))
      0: pick_key = 32'h0000_0000;
      1: pick_key = 32'hFFFF_FFFF;
      2: pick_key = 32'h0000_0001;
      3: pick_key = 32'h8000_0000;
      4: pick_key = 32'h1234_5678;
      5: pick_key = 32'hA5A5_A5A5;
      6: pick_key = 32'h5A5A_5A5A;
      default: pick_key = $urandom();
    endcase
  endfunction

  // Extremes of every field, every command and each corner case by name.
  task automatic test_directed();
    // Empty list: pops report empty, searches and scans report a miss.
    send_command(CMD_POP_FRONT, '0, '0, '0, '0);
    send_command(CMD_POP_BACK, '0, '0, '0, '0);
    send_command(CMD_LOOKUP, 32'h0, '0, '0, '0);
    send_command(CMD_REMOVE, 32'h0, '0, '0, '0);
    send_command(CMD_UPDATE, 32'h0, 10'd5, '0, '0);
    send_command(CMD_SCAN, '0, '0, '0, 10'd0);
    // Fill from both ends and by position: front, past the end, middle.
    send_command(CMD_PUSH_FRONT, 32'h0, 10'd0, '0, '0);
    send_command(CMD_PUSH_BACK, 32'hFFFF_FFFF, 10'd1023, '0, '0);
    send_command(CMD_INSERT, 32'h1234_5678, 10'd500, 5'd0, '0);
    send_command(CMD_INSERT, 32'hA5A5_A5A5, 10'd250, 5'd31, '0);
    send_command(CMD_INSERT, 32'h0, 10'd777, 5'd2, '0);
    send_command(CMD_INSERT, 32'h5A5A_5A5A, 10'd1, 5'd5, '0);
    // Duplicate key: only the first match is found, updated and removed.
    send_command(CMD_LOOKUP, 32'h0, '0, '0, '0);
    send_command(CMD_UPDATE, 32'h0, 10'd999, '0, '0);
    send_command(CMD_LOOKUP, 32'hDEAD_BEEF, '0, '0, '0);
    send_command(CMD_REMOVE, 32'h0, '0, '0, '0);
    // Scans: everything, only the top value, then no match on a busy list.
    send_command(CMD_SCAN, '0, '0, '0, 10'd0);
    send_command(CMD_SCAN, '0, '0, '0, 10'd1023);
    send_command(CMD_REMOVE, 32'hFFFF_FFFF, '0, '0, '0);
    send_command(CMD_SCAN, '0, '0, '0, 10'd1023);
    // Unused codes change nothing.
    send_command(CMD_UNUSED_LO, 32'hFFFF_FFFF, 10'd1023, 5'd31, 10'd1023);
    send_command(CMD_UNUSED_HI, 32'hFFFF_FFFF, 10'd1023, 5'd31, 10'd1023);
    send_command(CMD_POP_FRONT, '0, '0, '0, '0);
    send_command(CMD_POP_BACK, '0, '0, '0, '0);
    send_command(CMD_UPDATE, 32'hA5A5_A5A5, 10'd1023, '0, '0);
    wait_until_drained();
  endtask

  // Empty the list, then fill it past capacity while the receiver holds off,
  // so the block backs up and stalls its input; then a full scan, a pop and an insert.
  task automatic test_backpressure();
    int to_pop;
    to_pop = list_len;
    for (int i = 0; i < to_pop; i++) send_command(CMD_POP_BACK, '0, '0, '0, '0);
    hold_cycles = 80;
    for (int i = 0; i < CapacityDef; i++)
      send_command(CMD_PUSH_BACK, pick_key(), 10'($urandom_range(1023)), '0, '0);
    send_command(CMD_PUSH_FRONT, 32'hFFFF_FFFF, 10'd1023, '0, '0);
    send_command(CMD_PUSH_BACK, 32'h0, 10'd0, '0, '0);
    send_command(CMD_INSERT, 32'h1, 10'd1, 5'd3, '0);
    send_command(CMD_SCAN, '0, '0, '0, 10'd0);
    send_command(CMD_POP_FRONT, '0, '0, '0, '0);
    send_command(CMD_INSERT, 32'h8000_0000, 10'd512, 5'd7, '0);
    wait_until_drained();
  endtask

  // Random commands under one idling pattern.
  task automatic test_random_phase(input int send_idle, input int recv_stall,
                                   input int count);
    int pick;
    logic [CmdW-1:0] cmd;
    logic [ValW-1:0] thr;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 12) cmd = CMD_PUSH_FRONT;
      else if (pick < 24) cmd = CMD_PUSH_BACK;
      else if (pick < 38) cmd = CMD_INSERT;
      else if (pick < 47) cmd = CMD_POP_FRONT;
      else if (pick < 56) cmd = CMD_POP_BACK;
      else if (pick < 68) cmd = CMD_LOOKUP;
      else if (pick < 78) cmd = CMD_REMOVE;
      else if (pick < 88) cmd = CMD_UPDATE;
      else if (pick < 97) cmd = CMD_SCAN;
      else cmd = CmdW'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      thr = $urandom_range(1) ? 10'($urandom_range(1023)) : 10'($urandom_range(255));
      send_command(cmd, pick_key(), 10'($urandom_range(1023)),
                   5'($urandom_range(31)), thr);
    end
    wait_until_drained();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.command      = '0;
    in_ch.key          = '0;
    in_ch.value        = '0;
    in_ch.position     = '0;
    in_ch.threshold    = '0;
    out_ch.ready       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 40);
    test_random_phase(88, 0, 40);
    test_random_phase(0, 88, 40);
    test_random_phase(20, 20, 40);

    idle_pct  = 0;
    stall_pct = 0;
    repeat (SettleCycles) @(posedge clk);
    if (owed_results.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", owed_results.size());
    end

    $display("Ran %0d commands and checked %0d result items: directed corners,",
             cmds_taken, results_seen);
    $display("a full list under a long receiver hold-off, and four idling mixes.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/okrl_pkg.sv
design/okrl_ifs.sv
design/okrl_cell.sv
design/ordered_keyed_record_list.sv
test/ordered_keyed_record_list_tb.sv
